[rtl/gjk_pkg.sv]
// ----------------------------------------------------------------------------
// gjk_pkg
// Shared types and constants of the GJK simplex step unit: vector type,
// vector-unit operation codes and the request/response bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package gjk_pkg;

  // Coordinate width seen on the point inputs; at most 32 bits are used.
  localparam int COORD_WIDTH = 32;
  localparam int PT_BITS     = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

  localparam logic       CMD_START = 1'b0;
  localparam logic       CMD_NEXT  = 1'b1;
  localparam logic       REG_ITER_LIMIT = 1'b0;
  localparam logic [7:0] ITER_LIMIT_RESET = 8'd64;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  typedef enum logic [2:0] {
    VOP_SUB,
    VOP_NEG,
    VOP_CROSS,
    VOP_DOT,
    VOP_RENORM
  } vop_e;

  typedef struct packed {
    logic start;
    vop_e op;
    vec_t a;
    vec_t b;
  } vu_req_t;

  typedef struct packed {
    logic done;
    vec_t r;
    logic pos;
    logic neg;
  } vu_resp_t;

endpackage

`default_nettype wire

[rtl/gjk_vec_unit.sv]
// ----------------------------------------------------------------------------
// gjk_vec_unit
// Shared vector engine: subtract, negate and renormalize, and cross and dot
// products on one multiplier; non-dot results renormalize one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gjk_vec_unit
  import gjk_pkg::*;
(
  input  wire      clk_i,
  input  wire      rst_ni,
  input  vu_req_t  req_i,
  output vu_resp_t resp_o
);

  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_SHIFT,
    U_DONE
  } ust_e;

  ust_e ust_q, ust_d;
  vop_e op_q, op_d;
  logic [2:0] cnt_q, cnt_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [63:0] r0_q, r0_d, r1_q, r1_d, r2_q, r2_d;

  logic signed [31:0] ma, mb;
  logic [2:0] nterms, term;
  logic [1:0] tgt;
  logic       sub;
  logic       all_fit;

  function automatic logic fits(input logic signed [63:0] v);
    fits = (v[63:30] == '0) || (v[63:30] == '1);
  endfunction

  function automatic logic signed [63:0] ext(input logic signed [31:0] v);
    ext = {{32{v[31]}}, v};
  endfunction

  assign all_fit = fits(r0_q) && fits(r1_q) && fits(r2_q);
  assign nterms  = (op_q == VOP_CROSS) ? 3'd6 : 3'd3;
  assign term    = cnt_q - 3'd1;

  always_comb begin
    ma = req_i.a.x;
    mb = req_i.b.x;
    if (op_q == VOP_CROSS) begin
      case (cnt_q)
        3'd0: begin ma = req_i.a.y; mb = req_i.b.z; end
        3'd1: begin ma = req_i.a.z; mb = req_i.b.y; end
        3'd2: begin ma = req_i.a.z; mb = req_i.b.x; end
        3'd3: begin ma = req_i.a.x; mb = req_i.b.z; end
        3'd4: begin ma = req_i.a.x; mb = req_i.b.y; end
        default: begin ma = req_i.a.y; mb = req_i.b.x; end
      endcase
    end else begin
      case (cnt_q)
        3'd0:    begin ma = req_i.a.x; mb = req_i.b.x; end
        3'd1:    begin ma = req_i.a.y; mb = req_i.b.y; end
        default: begin ma = req_i.a.z; mb = req_i.b.z; end
      endcase
    end
  end

  always_comb begin
    if (op_q == VOP_CROSS) begin
      tgt = term[2:1];
      sub = term[0];
    end else begin
      tgt = 2'd0;
      sub = 1'b0;
    end
  end

  always_comb begin
    ust_d  = ust_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    prod_d = prod_q;
    r0_d   = r0_q;
    r1_d   = r1_q;
    r2_d   = r2_q;
    unique case (ust_q)
      U_IDLE: begin
        if (req_i.start) begin
          op_d  = req_i.op;
          cnt_d = 3'd0;
          unique case (req_i.op)
            VOP_SUB: begin
              r0_d  = ext(req_i.a.x) - ext(req_i.b.x);
              r1_d  = ext(req_i.a.y) - ext(req_i.b.y);
              r2_d  = ext(req_i.a.z) - ext(req_i.b.z);
              ust_d = U_SHIFT;
            end
            VOP_NEG: begin
              r0_d  = 64'sd0 - ext(req_i.a.x);
              r1_d  = 64'sd0 - ext(req_i.a.y);
              r2_d  = 64'sd0 - ext(req_i.a.z);
              ust_d = U_SHIFT;
            end
            VOP_RENORM: begin
              r0_d  = ext(req_i.a.x);
              r1_d  = ext(req_i.a.y);
              r2_d  = ext(req_i.a.z);
              ust_d = U_SHIFT;
            end
            default: begin
              r0_d  = '0;
              r1_d  = '0;
              r2_d  = '0;
              ust_d = U_MUL;
            end
          endcase
        end
      end
      U_MUL: begin
        // issue product cnt, fold in product cnt-1
        if (cnt_q < nterms) begin
          prod_d = ma * mb;
        end
        if (cnt_q != 3'd0) begin
          case (tgt)
            2'd0:    r0_d = sub ? r0_q - prod_q : r0_q + prod_q;
            2'd1:    r1_d = sub ? r1_q - prod_q : r1_q + prod_q;
            default: r2_d = sub ? r2_q - prod_q : r2_q + prod_q;
          endcase
        end
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == nterms) begin
          ust_d = (op_q == VOP_DOT) ? U_DONE : U_SHIFT;
        end
      end
      U_SHIFT: begin
        if (all_fit) begin
          ust_d = U_DONE;
        end else begin
          r0_d = r0_q >>> 1;
          r1_d = r1_q >>> 1;
          r2_d = r2_q >>> 1;
        end
      end
      U_DONE: begin
        ust_d = U_IDLE;
      end
      default: ust_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ust_q <= U_IDLE;
      op_q  <= VOP_SUB;
      cnt_q <= 3'd0;
    end else begin
      ust_q <= ust_d;
      op_q  <= op_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    r0_q   <= r0_d;
    r1_q   <= r1_d;
    r2_q   <= r2_d;
  end

  assign resp_o.done = (ust_q == U_DONE);
  assign resp_o.r.x  = r0_q[31:0];
  assign resp_o.r.y  = r1_q[31:0];
  assign resp_o.r.z  = r2_q[31:0];
  assign resp_o.pos  = (r0_q > 64'sd0);
  assign resp_o.neg  = r0_q[63];

endmodule

`default_nettype wire

[rtl/gjk_simplex_step_unit.sv]
// ----------------------------------------------------------------------------
// gjk_simplex_step_unit
// One GJK simplex step per item: seed, dot test, line/triangle/tetra case.
// ----------------------------------------------------------------------------
// Operations: an item runs up to 25 vector operations in turn on the shared
//   unit (cross products and other non-dot results end in renormalizing
//   shifts).
// Flow: one item at a time; paced by the single multiplier and the
//   one-bit-per-cycle shifter of the vector unit.
// Reset: asynchronous, active low; clears control state, heading, counts and
//   sets the iteration limit to 64. Vertex storage is not cleared.
`default_nettype none

module gjk_simplex_step_unit
  import gjk_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  // input items
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire               command_i,
  input  wire signed [31:0] point_x_i,
  input  wire signed [31:0] point_y_i,
  input  wire signed [31:0] point_z_i,
  // result items
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic signed [31:0] search_x_o,
  output logic signed [31:0] search_y_o,
  output logic signed [31:0] search_z_o,
  output logic [2:0]        point_count_o,
  output logic              finished_o,
  output logic              overlapping_o,
  // configuration
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [2:0]        paddr,
  input  wire  [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [5:0] {
    ST_IDLE, ST_START_NEG, ST_RN_P, ST_DOT_PH,
    ST_L_AB, ST_L_AO, ST_L_DOT, ST_L_X1, ST_L_X2,
    ST_T_AO, ST_T_AB, ST_T_AC, ST_T_N, ST_T_X1, ST_T_D1, ST_T_D2,
    ST_T_X2, ST_T_X3, ST_T_X4, ST_T_D3, ST_T_D4, ST_T_NEG,
    ST_Q_AO, ST_Q_AB, ST_Q_AC, ST_Q_AD, ST_Q_X1, ST_Q_D1,
    ST_Q_X2, ST_Q_D2, ST_Q_X3, ST_Q_D3,
    ST_CHECK, ST_EMIT
  } state_e;

  typedef enum logic [3:0] {
    SRC_P, SRC_QA, SRC_QB, SRC_QC, SRC_QD,
    SRC_AO, SRC_AB, SRC_AC, SRC_AD, SRC_N, SRC_T, SRC_H
  } src_e;

  state_e state_q, state_d;
  logic   issued_q, issued_d;

  // points: input item, working arguments and simplex vertices
  vec_t p_q, p_d, qa_q, qa_d, qb_q, qb_d, qc_q, qc_d, qd_q, qd_d;
  vec_t v0_q, v0_d, v1_q, v1_d, v2_q, v2_d;
  // renormalized temporaries and heading
  vec_t ao_q, ao_d, ab_q, ab_d, ac_q, ac_d, ad_q, ad_d;
  vec_t n_q, n_d, t_q, t_d, h_q, h_d;

  logic [2:0] count_q, count_d;
  logic [7:0] step_q, step_d;
  logic [7:0] limit_q;
  logic       running_q, running_d;
  logic       hit_q, hit_d;
  logic       fin_q, fin_d, ovl_q, ovl_d;
  logic       out_valid_q, out_valid_d;
  logic       out_load;

  logic       is_op;
  vop_e       op;
  src_e       sa, sb, dst;
  vec_t       opa, opb;
  vec_t       p_in;
  vu_req_t    vreq;
  vu_resp_t   vresp;

  // keep the low coordinate bits, sign extended
  assign p_in.x = $signed(point_x_i <<< (32 - PT_BITS)) >>> (32 - PT_BITS);
  assign p_in.y = $signed(point_y_i <<< (32 - PT_BITS)) >>> (32 - PT_BITS);
  assign p_in.z = $signed(point_z_i <<< (32 - PT_BITS)) >>> (32 - PT_BITS);

  function automatic vec_t pick(input src_e s, input vec_t p, input vec_t qa,
                                input vec_t qb, input vec_t qc, input vec_t qd,
                                input vec_t ao, input vec_t ab, input vec_t ac,
                                input vec_t ad, input vec_t n, input vec_t t,
                                input vec_t h);
    case (s)
      SRC_P:   pick = p;
      SRC_QA:  pick = qa;
      SRC_QB:  pick = qb;
      SRC_QC:  pick = qc;
      SRC_QD:  pick = qd;
      SRC_AO:  pick = ao;
      SRC_AB:  pick = ab;
      SRC_AC:  pick = ac;
      SRC_AD:  pick = ad;
      SRC_N:   pick = n;
      SRC_T:   pick = t;
      default: pick = h;
    endcase
  endfunction

  // operation table: what each sequencer step asks of the vector unit
  always_comb begin
    is_op = 1'b1;
    op    = VOP_SUB;
    sa    = SRC_P;
    sb    = SRC_P;
    dst   = SRC_T;
    unique case (state_q)
      ST_START_NEG: begin op = VOP_NEG;    sa = SRC_P;               dst = SRC_H;  end
      ST_RN_P:      begin op = VOP_RENORM; sa = SRC_P;               dst = SRC_T;  end
      ST_DOT_PH:    begin op = VOP_DOT;    sa = SRC_T;  sb = SRC_H;                end
      ST_L_AB:      begin op = VOP_SUB;    sa = SRC_QB; sb = SRC_QA; dst = SRC_AB; end
      ST_L_AO:      begin op = VOP_NEG;    sa = SRC_QA;              dst = SRC_AO; end
      ST_L_DOT:     begin op = VOP_DOT;    sa = SRC_AB; sb = SRC_AO;               end
      ST_L_X1:      begin op = VOP_CROSS;  sa = SRC_AB; sb = SRC_AO; dst = SRC_T;  end
      ST_L_X2:      begin op = VOP_CROSS;  sa = SRC_T;  sb = SRC_AB; dst = SRC_H;  end
      ST_T_AO:      begin op = VOP_NEG;    sa = SRC_QA;              dst = SRC_AO; end
      ST_T_AB:      begin op = VOP_SUB;    sa = SRC_QB; sb = SRC_QA; dst = SRC_AB; end
      ST_T_AC:      begin op = VOP_SUB;    sa = SRC_QC; sb = SRC_QA; dst = SRC_AC; end
      ST_T_N:       begin op = VOP_CROSS;  sa = SRC_AB; sb = SRC_AC; dst = SRC_N;  end
      ST_T_X1:      begin op = VOP_CROSS;  sa = SRC_N;  sb = SRC_AC; dst = SRC_T;  end
      ST_T_D1:      begin op = VOP_DOT;    sa = SRC_T;  sb = SRC_AO;               end
      ST_T_D2:      begin op = VOP_DOT;    sa = SRC_AC; sb = SRC_AO;               end
      ST_T_X2:      begin op = VOP_CROSS;  sa = SRC_AC; sb = SRC_AO; dst = SRC_T;  end
      ST_T_X3:      begin op = VOP_CROSS;  sa = SRC_T;  sb = SRC_AC; dst = SRC_H;  end
      ST_T_X4:      begin op = VOP_CROSS;  sa = SRC_AB; sb = SRC_N;  dst = SRC_T;  end
      ST_T_D3:      begin op = VOP_DOT;    sa = SRC_T;  sb = SRC_AO;               end
      ST_T_D4:      begin op = VOP_DOT;    sa = SRC_N;  sb = SRC_AO;               end
      ST_T_NEG:     begin op = VOP_NEG;    sa = SRC_N;               dst = SRC_H;  end
      ST_Q_AO:      begin op = VOP_NEG;    sa = SRC_QA;              dst = SRC_AO; end
      ST_Q_AB:      begin op = VOP_SUB;    sa = SRC_QB; sb = SRC_QA; dst = SRC_AB; end
      ST_Q_AC:      begin op = VOP_SUB;    sa = SRC_QC; sb = SRC_QA; dst = SRC_AC; end
      ST_Q_AD:      begin op = VOP_SUB;    sa = SRC_QD; sb = SRC_QA; dst = SRC_AD; end
      ST_Q_X1:      begin op = VOP_CROSS;  sa = SRC_AB; sb = SRC_AC; dst = SRC_T;  end
      ST_Q_D1:      begin op = VOP_DOT;    sa = SRC_T;  sb = SRC_AO;               end
      ST_Q_X2:      begin op = VOP_CROSS;  sa = SRC_AC; sb = SRC_AD; dst = SRC_T;  end
      ST_Q_D2:      begin op = VOP_DOT;    sa = SRC_T;  sb = SRC_AO;               end
      ST_Q_X3:      begin op = VOP_CROSS;  sa = SRC_AD; sb = SRC_AB; dst = SRC_T;  end
      ST_Q_D3:      begin op = VOP_DOT;    sa = SRC_T;  sb = SRC_AO;               end
      default:      is_op = 1'b0;
    endcase
  end

  assign opa = pick(sa, p_q, qa_q, qb_q, qc_q, qd_q, ao_q, ab_q, ac_q, ad_q,
                    n_q, t_q, h_q);
  assign opb = pick(sb, p_q, qa_q, qb_q, qc_q, qd_q, ao_q, ab_q, ac_q, ad_q,
                    n_q, t_q, h_q);

  assign vreq.start = is_op && !issued_q;
  assign vreq.op    = op;
  assign vreq.a     = opa;
  assign vreq.b     = opb;

  gjk_vec_unit u_vec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (vreq),
    .resp_o (vresp)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_load    = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  // sequencer
  always_comb begin
    state_d   = state_q;
    issued_d  = issued_q;
    p_d  = p_q;  qa_d = qa_q; qb_d = qb_q; qc_d = qc_q; qd_d = qd_q;
    v0_d = v0_q; v1_d = v1_q; v2_d = v2_q;
    ao_d = ao_q; ab_d = ab_q; ac_d = ac_q; ad_d = ad_q;
    n_d  = n_q;  t_d  = t_q;  h_d  = h_q;
    count_d   = count_q;
    step_d    = step_q;
    running_d = running_q;
    hit_d     = hit_q;
    fin_d     = fin_q;
    ovl_d     = ovl_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (is_op) begin
      if (!issued_q) begin
        issued_d = 1'b1;
      end else if (vresp.done) begin
        issued_d = 1'b0;
        if (op != VOP_DOT) begin
          case (dst)
            SRC_AO:  ao_d = vresp.r;
            SRC_AB:  ab_d = vresp.r;
            SRC_AC:  ac_d = vresp.r;
            SRC_AD:  ad_d = vresp.r;
            SRC_N:   n_d  = vresp.r;
            SRC_H:   h_d  = vresp.r;
            default: t_d  = vresp.r;
          endcase
        end
        unique case (state_q)
          ST_START_NEG: begin
            v0_d = p_q; count_d = 3'd1; step_d = 8'd0; running_d = 1'b1;
            fin_d = 1'b0; ovl_d = 1'b0;
            state_d = ST_EMIT;
          end
          ST_RN_P: state_d = ST_DOT_PH;
          ST_DOT_PH: begin
            if (vresp.neg) begin
              running_d = 1'b0; fin_d = 1'b1; ovl_d = 1'b0;
              state_d = ST_EMIT;
            end else begin
              if (step_q != 8'hFF) step_d = step_q + 8'd1;
              hit_d = 1'b0;
              qa_d  = p_q;
              if (count_q == 3'd1) begin
                qb_d = v0_q;
                state_d = ST_L_AB;
              end else if (count_q == 3'd2) begin
                qb_d = v1_q; qc_d = v0_q;
                state_d = ST_T_AO;
              end else begin
                qb_d = v2_q; qc_d = v1_q; qd_d = v0_q; count_d = 3'd4;
                state_d = ST_Q_AO;
              end
            end
          end
          ST_L_AB: state_d = ST_L_AO;
          ST_L_AO: state_d = ST_L_DOT;
          ST_L_DOT: begin
            if (vresp.pos) begin
              state_d = ST_L_X1;
            end else begin
              v0_d = qa_q; count_d = 3'd1; h_d = ao_q;
              state_d = ST_CHECK;
            end
          end
          ST_L_X1: state_d = ST_L_X2;
          ST_L_X2: begin
            v0_d = qb_q; v1_d = qa_q; count_d = 3'd2;
            state_d = ST_CHECK;
          end
          ST_T_AO: state_d = ST_T_AB;
          ST_T_AB: state_d = ST_T_AC;
          ST_T_AC: state_d = ST_T_N;
          ST_T_N:  state_d = ST_T_X1;
          ST_T_X1: state_d = ST_T_D1;
          ST_T_D1: state_d = vresp.pos ? ST_T_D2 : ST_T_X4;
          ST_T_D2: state_d = vresp.pos ? ST_T_X2 : ST_L_AB;
          ST_T_X2: state_d = ST_T_X3;
          ST_T_X3: begin
            v0_d = qc_q; v1_d = qa_q; count_d = 3'd2;
            state_d = ST_CHECK;
          end
          ST_T_X4: state_d = ST_T_D3;
          ST_T_D3: state_d = vresp.pos ? ST_L_AB : ST_T_D4;
          ST_T_D4: begin
            if (vresp.pos) begin
              v0_d = qc_q; v1_d = qb_q; v2_d = qa_q; count_d = 3'd3; h_d = n_q;
              state_d = ST_CHECK;
            end else begin
              state_d = ST_T_NEG;
            end
          end
          ST_T_NEG: begin
            v0_d = qb_q; v1_d = qc_q; v2_d = qa_q; count_d = 3'd3;
            state_d = ST_CHECK;
          end
          ST_Q_AO: state_d = ST_Q_AB;
          ST_Q_AB: state_d = ST_Q_AC;
          ST_Q_AC: state_d = ST_Q_AD;
          ST_Q_AD: state_d = ST_Q_X1;
          ST_Q_X1: state_d = ST_Q_D1;
          ST_Q_D1: state_d = vresp.pos ? ST_T_AO : ST_Q_X2;
          ST_Q_X2: state_d = ST_Q_D2;
          ST_Q_D2: begin
            if (vresp.pos) begin
              // face a, c, d
              qb_d = qc_q; qc_d = qd_q;
              state_d = ST_T_AO;
            end else begin
              state_d = ST_Q_X3;
            end
          end
          ST_Q_X3: state_d = ST_Q_D3;
          ST_Q_D3: begin
            if (vresp.pos) begin
              // face a, b, d
              qc_d = qd_q;
              state_d = ST_T_AO;
            end else begin
              hit_d = 1'b1;
              state_d = ST_CHECK;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            p_d = p_in;
            if (command_i == CMD_START) begin
              state_d = ST_START_NEG;
            end else if (!running_q) begin
              // next while idle: report as is
              fin_d = 1'b1; ovl_d = 1'b0;
              state_d = ST_EMIT;
            end else begin
              state_d = ST_RN_P;
            end
          end
        end
        ST_CHECK: begin
          if (hit_q) begin
            fin_d = 1'b1; ovl_d = 1'b1; running_d = 1'b0;
          end else if (step_q >= limit_q) begin
            fin_d = 1'b1; ovl_d = 1'b0; running_d = 1'b0;
          end else begin
            fin_d = 1'b0; ovl_d = 1'b0;
          end
          state_d = ST_EMIT;
        end
        ST_EMIT: begin
          if (out_load) begin
            out_valid_d = 1'b1;
            state_d = ST_IDLE;
          end
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      count_q     <= 3'd0;
      step_q      <= 8'd0;
      running_q   <= 1'b0;
      hit_q       <= 1'b0;
      fin_q       <= 1'b0;
      ovl_q       <= 1'b0;
      h_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      count_q     <= count_d;
      step_q      <= step_d;
      running_q   <= running_d;
      hit_q       <= hit_d;
      fin_q       <= fin_d;
      ovl_q       <= ovl_d;
      h_q         <= h_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q  <= p_d;  qa_q <= qa_d; qb_q <= qb_d; qc_q <= qc_d; qd_q <= qd_d;
    v0_q <= v0_d; v1_q <= v1_d; v2_q <= v2_d;
    ao_q <= ao_d; ab_q <= ab_d; ac_q <= ac_d; ad_q <= ad_d;
    n_q  <= n_d;  t_q  <= t_d;
    if (out_load) begin
      search_x_o    <= h_q.x;
      search_y_o    <= h_q.y;
      search_z_o    <= h_q.z;
      point_count_o <= count_q;
      finished_o    <= fin_q;
      overlapping_o <= ovl_q;
    end
  end

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= ITER_LIMIT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_ITER_LIMIT)) begin
      limit_q <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ITER_LIMIT) prdata = {24'd0, limit_q};
  end

endmodule

`default_nettype wire
